// ===== hdl/nrg_pkg.sv =====
package nrg_pkg;

  localparam int DATA_W         = 64;
  localparam int BYTE_BITS      = 8;
  localparam int SIZE_W         = 7;
  localparam int NTAP_CFG_W     = 5;
  localparam int SLOT_W         = 4;
  localparam int DEST_W         = 6;
  localparam int COUNT_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int NUM_TAPS_DEF   = 16;
  localparam int RING_WIDTH_DEF = 64;

  localparam logic [SIZE_W-1:0]     RING_SIZE_RESET   = SIZE_W'(64);
  localparam logic [NTAP_CFG_W-1:0] ACTIVE_TAPS_RESET = '0;
  localparam logic [DATA_W-1:0]     SEED_RESET        = DATA_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TAPS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_VALUE  = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    OP_WRITE_TAP = 2'd0,
    OP_TICK      = 2'd1,
    OP_RESTART   = 2'd2
  } op_t;

  typedef struct packed {
    logic write_tap;
    logic tick;
    logic restart;
  } nrg_cmd_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] seq_byte;
    logic [COUNT_W-1:0]   bit_count;
    logic                 run_done;
    logic                 period_found;
    logic [DATA_W-1:0]    period_steps;
  } nrg_result_t;

endpackage

// ===== hdl/nrg_in_if.sv =====
interface nrg_in_if;
  import nrg_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [SLOT_W-1:0]   tap_slot;
  logic [DEST_W-1:0]   dest_bit;
  logic                dest_invert;
  logic [DATA_W-1:0]   source_mask;
  logic [DATA_W-1:0]   source_invert;

  modport source (
    output valid, operation, tap_slot, dest_bit, dest_invert, source_mask, source_invert,
    input  ready
  );

  modport sink (
    input  valid, operation, tap_slot, dest_bit, dest_invert, source_mask, source_invert,
    output ready
  );

endinterface

// ===== hdl/nrg_out_if.sv =====
interface nrg_out_if;
  import nrg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] seq_byte;
  logic [COUNT_W-1:0]   bit_count;
  logic                 run_done;
  logic                 period_found;
  logic [DATA_W-1:0]    period_steps;

  modport source (
    output valid, seq_byte, bit_count, run_done, period_found, period_steps,
    input  ready
  );

  modport sink (
    input  valid, seq_byte, bit_count, run_done, period_found, period_steps,
    output ready
  );

endinterface

// ===== hdl/nrg_config.sv =====
module nrg_config #(
  parameter int NUM_TAPS   = nrg_pkg::NUM_TAPS_DEF,
  parameter int RING_WIDTH = nrg_pkg::RING_WIDTH_DEF,
  parameter int NTAP_W     = $clog2(NUM_TAPS + 1)
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      write_enable,
  input  logic [nrg_pkg::CFG_IDX_W-1:0]             write_index,
  input  logic [nrg_pkg::CFG_DATA_W-1:0]            write_data,
  output logic [nrg_pkg::SIZE_W-1:0]                size,
  output logic [NTAP_W-1:0]                         ntaps,
  output logic [nrg_pkg::DATA_W-1:0]                seed,
  output logic [RING_WIDTH-1:0][nrg_pkg::DATA_W-1:0] fold
);
  import nrg_pkg::*;

  logic [SIZE_W-1:0]                size_next;
  logic [SIZE_W-1:0]                size_raw;
  logic [RING_WIDTH-1:0][DATA_W-1:0] fold_next;
  logic [DATA_W-1:0][DATA_W:0]      div_tab;

  // Row j of the fold matrix marks the source bit indices that land on ring bit j.
  for (genvar d = 0; d < DATA_W; d++) begin : g_div
    for (genvar s = 0; s <= DATA_W; s++) begin : g_s
      if (s < 2) begin : g_none
        assign div_tab[d][s] = 1'b0;
      end else begin : g_chk
        localparam bit DIVIDES = ((d % s) == 0);
        assign div_tab[d][s] = DIVIDES;
      end
    end
  end

  always_comb begin
    size_raw = RING_SIZE_RESET;
    if (!rst && write_enable && write_index == CFG_RING_SIZE) begin
      size_raw = write_data[SIZE_W-1:0];
    end
    size_next = size;
    if (rst || (write_enable && write_index == CFG_RING_SIZE)) begin
      if (size_raw < SIZE_W'(2)) begin
        size_next = SIZE_W'(2);
      end else if (size_raw > SIZE_W'(RING_WIDTH)) begin
        size_next = SIZE_W'(RING_WIDTH);
      end else begin
        size_next = size_raw;
      end
    end
  end

  for (genvar j = 0; j < RING_WIDTH; j++) begin : g_row
    for (genvar i = 0; i < DATA_W; i++) begin : g_col
      if (i >= j) begin : g_on
        assign fold_next[j][i] = (SIZE_W'(j) < size_next) && div_tab[i-j][size_next];
      end else begin : g_off
        assign fold_next[j][i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    size <= size_next;
    fold <= fold_next;
    if (rst) begin
      ntaps <= NTAP_W'(ACTIVE_TAPS_RESET);
      seed  <= SEED_RESET;
    end else if (write_enable) begin
      if (write_index == CFG_ACTIVE_TAPS) begin
        if (int'(write_data[NTAP_CFG_W-1:0]) > NUM_TAPS) begin
          ntaps <= NTAP_W'(NUM_TAPS);
        end else begin
          ntaps <= NTAP_W'(write_data[NTAP_CFG_W-1:0]);
        end
      end else if (write_index == CFG_SEED_VALUE) begin
        seed <= write_data[DATA_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/nrg_tap_bank.sv =====
module nrg_tap_bank #(
  parameter int NUM_TAPS   = nrg_pkg::NUM_TAPS_DEF,
  parameter int RING_WIDTH = nrg_pkg::RING_WIDTH_DEF,
  parameter int NTAP_W     = $clog2(NUM_TAPS + 1)
) (
  input  logic                                       clk,
  input  logic                                       write_tap,
  input  logic [nrg_pkg::SLOT_W-1:0]                 tap_slot,
  input  logic [nrg_pkg::DEST_W-1:0]                 dest_bit,
  input  logic                                       dest_invert,
  input  logic [nrg_pkg::DATA_W-1:0]                 source_mask,
  input  logic [nrg_pkg::DATA_W-1:0]                 source_invert,
  input  logic [NTAP_W-1:0]                          ntaps,
  input  logic [RING_WIDTH-1:0][nrg_pkg::DATA_W-1:0] fold,
  input  logic [RING_WIDTH-1:0]                      ring,
  output logic [RING_WIDTH-1:0]                      toggle
);
  import nrg_pkg::*;

  logic [NUM_TAPS-1:0][DATA_W-1:0] dest_oh;
  logic [NUM_TAPS-1:0]             dest_inv;
  logic [NUM_TAPS-1:0][DATA_W-1:0] want_one;
  logic [NUM_TAPS-1:0][DATA_W-1:0] want_zero;
  logic [NUM_TAPS-1:0]             fire;
  logic [DATA_W-1:0]               dest_sel;

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (write_tap && int'(tap_slot) == k) begin
        dest_oh[k]   <= DATA_W'(1) << dest_bit;
        dest_inv[k]  <= dest_invert;
        want_one[k]  <= source_mask & ~source_invert;
        want_zero[k] <= source_mask & source_invert;
      end
    end
  end

  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
    logic [RING_WIDTH-1:0] need_one;
    logic [RING_WIDTH-1:0] need_zero;
    logic                  term;

    always_comb begin
      for (int j = 0; j < RING_WIDTH; j++) begin
        need_one[j]  = |(fold[j] & want_one[k]);
        need_zero[j] = |(fold[j] & want_zero[k]);
      end
      term    = &((~need_one | ring) & (~need_zero | ~ring));
      fire[k] = (int'(ntaps) > k) && (term ^ dest_inv[k]);
    end
  end

  // Taps that land on the same ring bit cancel in pairs.
  always_comb begin
    dest_sel = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (fire[k]) begin
        dest_sel = dest_sel ^ dest_oh[k];
      end
    end
    for (int j = 0; j < RING_WIDTH; j++) begin
      toggle[j] = ^(fold[j] & dest_sel);
    end
  end

endmodule

// ===== hdl/nrg_core.sv =====
module nrg_core #(
  parameter int RING_WIDTH = nrg_pkg::RING_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nrg_pkg::nrg_cmd_t           cmd,
  input  logic [nrg_pkg::SIZE_W-1:0]  size,
  input  logic [nrg_pkg::DATA_W-1:0]  seed,
  input  logic [RING_WIDTH-1:0]       toggle,
  output logic [RING_WIDTH-1:0]       ring_masked,
  output logic                        res_valid,
  output nrg_pkg::nrg_result_t        res
);
  import nrg_pkg::*;

  logic [RING_WIDTH-1:0] ring_value;
  logic [DATA_W-1:0]     step_count;
  logic [BYTE_BITS-1:0]  bit_shift;
  logic [COUNT_W-1:0]    bits_held;
  logic                  run_over;

  logic [RING_WIDTH-1:0] size_mask;
  logic [RING_WIDTH-1:0] top_oh;
  logic [RING_WIDTH-1:0] rotated;
  logic [RING_WIDTH-1:0] ring_next;
  logic [RING_WIDTH-1:0] seed_masked;
  logic [DATA_W-1:0]     step_next;
  logic [DATA_W-1:0]     size_pow;
  logic [BYTE_BITS-1:0]  shift_next;
  logic [COUNT_W-1:0]    held_next;
  logic                  out_bit;
  logic                  found;
  logic                  limit;
  logic                  done;
  logic                  emit;
  logic                  step_on;

  always_comb begin
    for (int j = 0; j < RING_WIDTH; j++) begin
      size_mask[j] = SIZE_W'(j) < size;
      top_oh[j]    = SIZE_W'(j + 1) == size;
    end
    ring_masked = ring_value & size_mask;
    seed_masked = seed[RING_WIDTH-1:0] & size_mask;
    out_bit     = ring_masked[0];
    rotated     = (ring_masked >> 1) | (out_bit ? top_oh : '0);
    ring_next   = rotated ^ toggle;
    step_next   = (step_count == '1) ? step_count : step_count + DATA_W'(1);
    size_pow    = DATA_W'(1) << size;
    found       = ring_next == seed_masked;
    if (size == SIZE_W'(DATA_W)) begin
      limit = step_count == '1;
    end else begin
      limit = step_next == size_pow;
    end
    done       = found || limit;
    shift_next = {bit_shift[BYTE_BITS-2:0], out_bit};
    held_next  = bits_held + COUNT_W'(1);
    emit       = (held_next == COUNT_W'(BYTE_BITS)) || done;
    step_on    = cmd.tick && !run_over;
    res_valid  = step_on && emit;

    res.seq_byte     = shift_next;
    res.bit_count    = held_next;
    res.run_done     = done;
    res.period_found = found;
    res.period_steps = found ? step_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_value <= RING_WIDTH'(SEED_RESET);
      step_count <= '0;
      bit_shift  <= '0;
      bits_held  <= '0;
      run_over   <= 1'b0;
    end else if (cmd.restart) begin
      ring_value <= seed_masked;
      step_count <= '0;
      bit_shift  <= '0;
      bits_held  <= '0;
      run_over   <= 1'b0;
    end else if (step_on) begin
      ring_value <= ring_next;
      step_count <= step_next;
      if (emit) begin
        bit_shift <= '0;
        bits_held <= '0;
        run_over  <= done;
      end else begin
        bit_shift <= shift_next;
        bits_held <= held_next;
      end
    end
  end

endmodule

// ===== hdl/nonlinear_ring_generator.sv =====
// An accepted item is held in the input register; a tick that fills a byte or ends
// the run then loads the result register. Throughput: one item per cycle unless a
// tick stalls behind an undrained result; each tick is a single pass through the tap
// bank, where all taps are evaluated in parallel from the registered ring value.
// Reset is synchronous and active high; it restores the configuration and ring
// state to their defaults. The tap table holds no reset value until written.
module nonlinear_ring_generator #(
  parameter int NUM_TAPS   = nrg_pkg::NUM_TAPS_DEF,
  parameter int RING_WIDTH = nrg_pkg::RING_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [nrg_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [nrg_pkg::CFG_DATA_W-1:0] write_data,
  nrg_in_if.sink                         items,
  nrg_out_if.source                      results
);
  import nrg_pkg::*;

  localparam int NTAP_W = $clog2(NUM_TAPS + 1);

  logic                  in_valid;
  logic [1:0]            in_op;
  logic [SLOT_W-1:0]     in_slot;
  logic [DEST_W-1:0]     in_dest;
  logic                  in_dinv;
  logic [DATA_W-1:0]     in_mask;
  logic [DATA_W-1:0]     in_inv;
  logic                  stall;
  logic                  issue;
  nrg_cmd_t              cmd;

  logic                  out_valid;
  nrg_result_t           out_data;
  logic                  res_valid;
  nrg_result_t           res;

  logic [SIZE_W-1:0]                 size;
  logic [NTAP_W-1:0]                 ntaps;
  logic [DATA_W-1:0]                 seed;
  logic [RING_WIDTH-1:0][DATA_W-1:0] fold;
  logic [RING_WIDTH-1:0]             ring_masked;
  logic [RING_WIDTH-1:0]             toggle;

  // A tick waits while the result register is full and not being drained.
  assign stall       = in_valid && in_op == OP_TICK && out_valid && !results.ready;
  assign issue       = in_valid && !stall;
  assign items.ready = !in_valid || !stall;

  assign cmd.write_tap = issue && in_op == OP_WRITE_TAP;
  assign cmd.tick      = issue && in_op == OP_TICK;
  assign cmd.restart   = issue && in_op == OP_RESTART;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
    if (items.valid && items.ready) begin
      in_op   <= items.operation;
      in_slot <= items.tap_slot;
      in_dest <= items.dest_bit;
      in_dinv <= items.dest_invert;
      in_mask <= items.source_mask;
      in_inv  <= items.source_invert;
    end
  end

  nrg_config #(
    .NUM_TAPS   (NUM_TAPS),
    .RING_WIDTH (RING_WIDTH),
    .NTAP_W     (NTAP_W)
  ) u_config (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .size         (size),
    .ntaps        (ntaps),
    .seed         (seed),
    .fold         (fold)
  );

  nrg_tap_bank #(
    .NUM_TAPS   (NUM_TAPS),
    .RING_WIDTH (RING_WIDTH),
    .NTAP_W     (NTAP_W)
  ) u_tap_bank (
    .clk           (clk),
    .write_tap     (cmd.write_tap),
    .tap_slot      (in_slot),
    .dest_bit      (in_dest),
    .dest_invert   (in_dinv),
    .source_mask   (in_mask),
    .source_invert (in_inv),
    .ntaps         (ntaps),
    .fold          (fold),
    .ring          (ring_masked),
    .toggle        (toggle)
  );

  nrg_core #(
    .RING_WIDTH (RING_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .size        (size),
    .seed        (seed),
    .toggle      (toggle),
    .ring_masked (ring_masked),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid) begin
      out_data <= res;
    end
  end

  assign results.valid        = out_valid;
  assign results.seq_byte     = out_data.seq_byte;
  assign results.bit_count    = out_data.bit_count;
  assign results.run_done     = out_data.run_done;
  assign results.period_found = out_data.period_found;
  assign results.period_steps = out_data.period_steps;

endmodule
